### src/mqpm_pkg.sv
package mqpm_pkg;

    // apb register map
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam logic REG_CMD_ENTRIES = 1'b0;
    localparam logic REG_RSP_ENTRIES = 1'b1;
    localparam logic [15:0] ENTRIES_RESET = 16'd1024;

    typedef enum logic [1:0] {
        KIND_ENQUEUE      = 2'd0,
        KIND_ADVANCE_TAIL = 2'd1,
        KIND_ADVANCE_HEAD = 2'd2,
        KIND_DRAIN        = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        status_t      status;
        logic [14:0]  slot_index;
        logic [31:0]  sequence_number;
        logic [15:0]  new_pointer;
        logic [15:0]  entry_count;
        logic         doorbell;
    } result_t;

endpackage

### src/mqpm_apb_regs.sv
module mqpm_apb_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mqpm_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [mqpm_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [mqpm_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output logic [15:0]                         cmd_entries,
    output logic [15:0]                         rsp_entries
);
    import mqpm_pkg::*;

    logic [15:0] cmd_entries_reg;
    logic [15:0] rsp_entries_reg;
    logic        wr_en;

    // registers sit on 4-byte boundaries, low address bits ignored
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_entries_reg <= ENTRIES_RESET;
            rsp_entries_reg <= ENTRIES_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_CMD_ENTRIES: cmd_entries_reg <= pwdata[15:0];
                REG_RSP_ENTRIES: rsp_entries_reg <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CMD_ENTRIES: prdata = CFG_DATA_BITS'(cmd_entries_reg);
            REG_RSP_ENTRIES: prdata = CFG_DATA_BITS'(rsp_entries_reg);
        endcase
    end

    assign cmd_entries = cmd_entries_reg;
    assign rsp_entries = rsp_entries_reg;

endmodule

### src/mqpm_step.sv
module mqpm_step #(
    parameter int POSITION_BITS = 15
) (
    input  logic [1:0]               kind,
    input  logic [POSITION_BITS:0]   dev_cmd_head,
    input  logic [POSITION_BITS:0]   dev_rsp_tail,
    input  logic [15:0]              amount,
    input  logic [15:0]              cmd_entries,
    input  logic [15:0]              rsp_entries,
    input  logic [POSITION_BITS:0]   cmd_tail,
    input  logic [POSITION_BITS:0]   rsp_head,
    input  logic [31:0]              seq,
    output mqpm_pkg::result_t        result,
    output logic [POSITION_BITS:0]   cmd_tail_next,
    output logic [POSITION_BITS:0]   rsp_head_next,
    output logic [31:0]              seq_next
);
    import mqpm_pkg::*;

    localparam int PW = POSITION_BITS + 1;   // pointer with wrap bit
    localparam int NW = POSITION_BITS + 3;   // signed pending count
    localparam logic [PW-1:0] WRAP = PW'(1) << POSITION_BITS;
    localparam logic [16:0] MAX_ENTRIES = 17'(1) << POSITION_BITS;

    function automatic logic [PW-1:0] eff_size(input logic [15:0] r);
        if (r == 16'd0) begin
            return PW'(1);
        end else if (17'(r) > MAX_ENTRIES) begin
            return WRAP;
        end
        return r[PW-1:0];
    endfunction

    function automatic logic [NW-1:0] pending_cnt(input logic [PW-1:0] head,
                                                  input logic [PW-1:0] tail,
                                                  input logic [PW-1:0] size);
        logic [NW-1:0] h;
        logic [NW-1:0] t;
        h = NW'(head[POSITION_BITS-1:0]);
        t = NW'(tail[POSITION_BITS-1:0]);
        if (head[POSITION_BITS] != tail[POSITION_BITS]) begin
            return NW'(size) + t - h;
        end
        return t - h;
    endfunction

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] ptr,
                                              input logic [PW-1:0] inc,
                                              input logic [PW-1:0] size);
        logic [PW:0] sum;
        sum = (PW+1)'(ptr[POSITION_BITS-1:0]) + (PW+1)'(inc);
        if (sum >= (PW+1)'(size)) begin
            return (ptr + inc - size) ^ WRAP;
        end
        return ptr + inc;
    endfunction

    logic [PW-1:0] csize, rsize;
    logic [NW-1:0] n_cmd, n_rsp;
    logic          bad_cmd, bad_rsp;
    logic [PW-1:0] cnt_cmd, cnt_rsp;
    logic          amt_over_c, amt_over_r;
    logic          full;
    logic [PW-1:0] cmd_inc, rsp_inc;
    logic [PW-1:0] cmd_adv, rsp_adv;

    assign csize = eff_size(cmd_entries);
    assign rsize = eff_size(rsp_entries);

    // pending counts; negative or above size means the device index is bogus
    assign n_cmd   = pending_cnt(dev_cmd_head, cmd_tail, csize);
    assign n_rsp   = pending_cnt(rsp_head, dev_rsp_tail, rsize);
    assign bad_cmd = n_cmd[NW-1] || (n_cmd > NW'(csize));
    assign bad_rsp = n_rsp[NW-1] || (n_rsp > NW'(rsize));
    assign cnt_cmd = n_cmd[PW-1:0];
    assign cnt_rsp = n_rsp[PW-1:0];

    assign amt_over_c = amount > 16'(csize);
    assign amt_over_r = amount > 16'(rsize);
    assign full       = dev_cmd_head == (cmd_tail ^ WRAP);

    assign cmd_inc = (kind_t'(kind) == KIND_ENQUEUE) ? PW'(1) : amount[PW-1:0];
    assign rsp_inc = (kind_t'(kind) == KIND_ADVANCE_HEAD) ? amount[PW-1:0] : cnt_rsp;
    assign cmd_adv = advance(cmd_tail, cmd_inc, csize);
    assign rsp_adv = advance(rsp_head, rsp_inc, rsize);

    always_comb begin
        result        = '0;
        result.status = ST_OK;
        cmd_tail_next = cmd_tail;
        rsp_head_next = rsp_head;
        seq_next      = seq;
        unique case (kind_t'(kind))
            KIND_ENQUEUE: begin
                if (full) begin
                    result.status = ST_FULL;
                end else if (bad_cmd) begin
                    result.status = ST_INVALID;
                end else if (cnt_cmd == csize) begin
                    result.status = ST_NOSPACE;
                end else begin
                    result.slot_index      = 15'(cmd_tail[POSITION_BITS-1:0]);
                    result.sequence_number = seq;
                    result.new_pointer     = 16'(cmd_adv);
                    result.doorbell        = 1'b1;
                    cmd_tail_next          = cmd_adv;
                    seq_next               = seq + 32'd1;
                end
            end
            KIND_ADVANCE_TAIL: begin
                if (amt_over_c || bad_cmd) begin
                    result.status = ST_INVALID;
                end else if (amount > 16'(csize - cnt_cmd)) begin
                    result.status = ST_NOSPACE;
                end else begin
                    result.new_pointer = 16'(cmd_adv);
                    cmd_tail_next      = cmd_adv;
                end
            end
            KIND_ADVANCE_HEAD: begin
                if (amt_over_r || bad_rsp || (amount > 16'(cnt_rsp))) begin
                    result.status = ST_INVALID;
                end else begin
                    result.new_pointer = 16'(rsp_adv);
                    rsp_head_next      = rsp_adv;
                end
            end
            KIND_DRAIN: begin
                if (bad_rsp) begin
                    result.status = ST_INVALID;
                end else begin
                    result.slot_index  = 15'(rsp_head[POSITION_BITS-1:0]);
                    result.entry_count = 16'(cnt_rsp);
                    result.new_pointer = 16'(rsp_adv);
                    result.doorbell    = cnt_rsp == rsize;
                    rsp_head_next      = rsp_adv;
                end
            end
        endcase
    end

endmodule

### src/mailbox_queue_pointer_manager.sv
// host-side pointer manager for a command queue and a response queue
// - input channel (s_valid/s_ready): one request word per handshake, giving the
//   kind (enqueue, advance command tail, advance response head, drain responses),
//   the device's command head and response tail, and an advance amount
// - result channel (m_valid/m_ready): exactly one result word per request with
//   status, slot, sequence number, new pointer, drain count and doorbell
// - apb port: queue sizes for both queues at byte addresses 0 and 4, pready tied high
// - pointers carry POSITION_BITS of position plus a wrap bit above them
// - flow: an accepted word is held in the request register, processed and moved
//   into the result register once it is free or being emptied, raising m_valid
// - throughput: one word per cycle while m_ready is high, set by the single-pass
//   update of the pointer and sequence state between request and result registers
// - receiver stall: the result register holds; one more word waits in the request
//   register, then s_ready drops until m_ready returns
// - reset (aresetn low, synchronous): both channels empty, command tail, response
//   head and sequence counter cleared, both queue sizes back to 1024 entries
module mailbox_queue_pointer_manager #(
    parameter int POSITION_BITS = 15
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // apb configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mqpm_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [mqpm_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [mqpm_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_kind,
    input  logic [15:0]                         s_device_command_head,
    input  logic [15:0]                         s_device_response_tail,
    input  logic [15:0]                         s_amount,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [14:0]                         m_slot_index,
    output logic [31:0]                         m_sequence_number,
    output logic [15:0]                         m_new_pointer,
    output logic [15:0]                         m_entry_count,
    output logic                                m_doorbell
);
    import mqpm_pkg::*;

    localparam int PW = POSITION_BITS + 1;

    logic [15:0]   cmd_entries, rsp_entries;

    // request register
    logic          in_valid_reg;
    logic [1:0]    kind_reg;
    logic [PW-1:0] dhead_reg, dtail_reg;
    logic [15:0]   amount_reg;

    // pointer state
    logic [PW-1:0] cmd_tail_reg, rsp_head_reg;
    logic [31:0]   seq_reg;
    logic [PW-1:0] cmd_tail_next, rsp_head_next;
    logic [31:0]   seq_next;

    // result register
    logic          out_valid_reg;
    result_t       result_reg;
    result_t       result_next;

    logic          in_adv;
    logic          in_take;

    mqpm_apb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cmd_entries (cmd_entries),
        .rsp_entries (rsp_entries)
    );

    mqpm_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .kind          (kind_reg),
        .dev_cmd_head  (dhead_reg),
        .dev_rsp_tail  (dtail_reg),
        .amount        (amount_reg),
        .cmd_entries   (cmd_entries),
        .rsp_entries   (rsp_entries),
        .cmd_tail      (cmd_tail_reg),
        .rsp_head      (rsp_head_reg),
        .seq           (seq_reg),
        .result        (result_next),
        .cmd_tail_next (cmd_tail_next),
        .rsp_head_next (rsp_head_next),
        .seq_next      (seq_next)
    );

    // the request moves on whenever the result register is free or being emptied
    assign in_adv  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || in_adv;
    assign in_take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cmd_tail_reg  <= '0;
            rsp_head_reg  <= '0;
            seq_reg       <= '0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (in_adv) begin
                in_valid_reg <= 1'b0;
            end

            // state commits in the same cycle the result is registered
            if (in_adv) begin
                out_valid_reg <= 1'b1;
                cmd_tail_reg  <= cmd_tail_next;
                rsp_head_reg  <= rsp_head_next;
                seq_reg       <= seq_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (in_take) begin
            kind_reg   <= s_kind;
            dhead_reg  <= s_device_command_head[PW-1:0];
            dtail_reg  <= s_device_response_tail[PW-1:0];
            amount_reg <= s_amount;
        end
        if (in_adv) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = result_reg.status;
    assign m_slot_index      = result_reg.slot_index;
    assign m_sequence_number = result_reg.sequence_number;
    assign m_new_pointer     = result_reg.new_pointer;
    assign m_entry_count     = result_reg.entry_count;
    assign m_doorbell        = result_reg.doorbell;

endmodule
